// ===== hdl/conv3x3_sharpen_edge_defines.svh =====
// Assertion helpers shared by the block. All sample on clk and are off during reset.
`ifndef CONV3X3_SHARPEN_EDGE_DEFINES_SVH
`define CONV3X3_SHARPEN_EDGE_DEFINES_SVH

// Same-cycle implication.
`define CVSE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CVSE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cvse_pkg.sv =====
`timescale 1ns / 1ps

package cvse_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int SAMPLE_W   = 8;
    localparam int PIXEL_W    = 3 * SAMPLE_W;
    localparam int SUM_W      = 12;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 13;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_SELECT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEGATE_SUM    = 3'd4;

    // Kernel codes; the unused code falls back to the Laplacian
    localparam logic [1:0] KERNEL_LAPLACE = 2'd0;
    localparam logic [1:0] KERNEL_SOBEL_H = 2'd1;
    localparam logic [1:0] KERNEL_SOBEL_V = 2'd2;

    typedef logic [PIXEL_W-1:0]         pixel_t;
    typedef logic [8:0][PIXEL_W-1:0]    window_t;

    typedef struct packed {
        logic [1:0] kernel;
        logic       edge_only;
        logic       negate;
    } filt_cfg_t;

endpackage

// ===== hdl/cvse_if.sv =====
`timescale 1ns / 1ps

// Pixel word into the block.
interface cvse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;

    modport source (output valid, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, in_blue, in_green, in_red, output ready);
endinterface

// Result word out of the block.
interface cvse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       run_last;
    logic       frame_last;

    modport source (output valid, out_blue, out_green, out_red, run_last, frame_last,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, run_last, frame_last,
                    output ready);
endinterface

// ===== hdl/cvse_filter.sv =====
`timescale 1ns / 1ps

// 3x3 kernel over one window, all three colour channels, with negate,
// optional centre add and clamp to 0..255.
module cvse_filter
    import cvse_pkg::*;
(
    input  window_t   win,
    input  filt_cfg_t cfg,
    output pixel_t    result
);

    function automatic logic [SAMPLE_W-1:0] filter_channel(
        input window_t   w,
        input int        ch,
        input filt_cfg_t c
    );
        logic signed [SUM_W-1:0] t [9];
        logic signed [SUM_W-1:0] sum;
        for (int k = 0; k < 9; k++)
        begin
            t[k] = $signed({{(SUM_W-SAMPLE_W){1'b0}}, w[k][ch*SAMPLE_W +: SAMPLE_W]});
        end
        unique case (c.kernel)
            KERNEL_SOBEL_H:
            begin
                sum = t[0] + (t[1] <<< 1) + t[2] - t[6] - (t[7] <<< 1) - t[8];
            end
            KERNEL_SOBEL_V:
            begin
                sum = t[0] + (t[3] <<< 1) + t[6] - t[2] - (t[5] <<< 1) - t[8];
            end
            default:
            begin
                sum = t[1] + t[3] + t[5] + t[7] - (t[4] <<< 2);
            end
        endcase
        if (c.negate)
        begin
            sum = -sum;
        end
        if (!c.edge_only)
        begin
            sum = sum + t[4];
        end
        if (sum < 0)
        begin
            return '0;
        end
        else if (sum > 255)
        begin
            return '1;
        end
        return sum[SAMPLE_W-1:0];
    endfunction

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            result[ch*SAMPLE_W +: SAMPLE_W] = filter_channel(win, ch, cfg);
        end
    end

endmodule

// ===== hdl/conv3x3_sharpen_edge.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// in_px     in   24     blue, green, red of the next raster pixel
// out_px    out  26     filtered blue, green, red, run_last, frame_last
// cfg       in   17     write enable, register index (3), write data (13)
//
// Rate: pixels with one result or none are taken at one per cycle while out_px.ready
//   holds; a pixel at the end of a row or in the last row causes up to 4 results,
//   which queue through the single output register at one result per cycle.
// Path: from acceptance, a pixel passes the line store read, the window update and
//   the output register before its first result word shows.
// Reset: counters, window and valid flags clear at once; the line store is never
//   cleared, so no clearing pass is needed.
// Stalls: a held result word stalls the result sequencer, which holds the line store
//   stage, which drops in_px.ready.
`include "conv3x3_sharpen_edge_defines.svh"

module conv3x3_sharpen_edge
    import cvse_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    cvse_in_if.sink                in_px,
    cvse_out_if.source             out_px
);

    // Result kinds, in emission order
    localparam logic [1:0] RES_MID       = 2'd0;  // window rows 0..2
    localparam logic [1:0] RES_MID_EDGE  = 2'd1;  // same, right column replicated
    localparam logic [1:0] RES_LOW       = 2'd2;  // rows 1,2,2 (bottom border)
    localparam logic [1:0] RES_LOW_EDGE  = 2'd3;  // bottom-right corner of frame

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [1:0]              kernel_reg;
    logic                    mode_reg;
    logic                    negate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(640);
            height_reg <= HEIGHT_REG_W'(480);
            kernel_reg <= KERNEL_LAPLACE;
            mode_reg   <= 1'b0;
            negate_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                REG_KERNEL_SELECT: kernel_reg <= cfg_data[1:0];
                REG_OUTPUT_MODE:   mode_reg   <= cfg_data[0];
                REG_NEGATE_SUM:    negate_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Last column and row index after the zero and maximum limits.
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        if (width_reg == '0)
        begin
            col_last = '0;
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(width_reg - WIDTH_REG_W'(1));
        end

        if (height_reg == '0)
        begin
            row_last = '0;
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            row_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last = ROW_W'(height_reg - HEIGHT_REG_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Handshake glue between the stages
    // ------------------------------------------------------------------
    logic       a_valid_reg;
    logic       a_adv;
    logic [3:0] e_mask_reg;
    logic       e_done;
    logic       emit_ok;
    logic       emit_fire;
    logic       accept;

    assign in_px.ready = !a_valid_reg || a_adv;
    assign accept      = in_px.valid && in_px.ready;

    // ------------------------------------------------------------------
    // Position counters: saturate to the current size, then advance.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next, c_eff;
    logic [ROW_W-1:0] row_reg, row_next, r_eff;
    logic             last_col, last_row;

    always_comb
    begin
        c_eff    = (col_reg > col_last) ? col_last : col_reg;
        r_eff    = (row_reg > row_last) ? row_last : row_reg;
        last_col = (c_eff == col_last);
        last_row = (r_eff == row_last);
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r_eff + ROW_W'(1);
        end
        else
        begin
            col_next = c_eff + COL_W'(1);
            row_next = r_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one word per column holds {row two above, row one above}.
    // Read on acceptance, written back when the word leaves stage A.
    // ------------------------------------------------------------------
    logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] mem_q_reg;
    logic [2*PIXEL_W-1:0] fwd_data_reg;
    logic                 fwd_reg;
    logic [2*PIXEL_W-1:0] q_eff;
    logic [2*PIXEL_W-1:0] wr_data;

    // Stage A payload
    pixel_t           a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    logic             a_first_reg;
    logic             a_r1_reg;
    logic             a_r2_reg;
    logic [3:0]       a_mask_reg;

    assign q_eff   = fwd_reg ? fwd_data_reg : mem_q_reg;
    // Shift the column down: lower row moves to upper, new pixel becomes lower.
    assign wr_data = {q_eff[PIXEL_W-1:0], a_pix_reg};

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            line_mem[a_col_reg] <= wr_data;
        end
        if (accept)
        begin
            mem_q_reg <= line_mem[c_eff];
        end
    end

    // Same column read as written (width one, or a shrink): take the new word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_reg <= a_adv && (a_col_reg == c_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wr_data;
            a_pix_reg    <= {in_px.in_red, in_px.in_green, in_px.in_blue};
            a_col_reg    <= c_eff;
            a_first_reg  <= (c_eff == '0);
            a_r1_reg     <= (r_eff != '0);
            a_r2_reg     <= (r_eff > ROW_W'(1));
            // One bit per result this pixel causes, in emission order
            a_mask_reg   <= {last_row && last_col,
                             last_row && (c_eff != '0),
                             (r_eff != '0) && last_col,
                             (r_eff != '0) && (c_eff != '0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Advance A once the sequencer has issued, or is issuing, its last result.
    assign a_adv = a_valid_reg && e_done;

    // ------------------------------------------------------------------
    // 3x3 window, newest column on the right
    // ------------------------------------------------------------------
    logic [2:0][2:0][PIXEL_W-1:0] win_reg;
    pixel_t [2:0]                 vals;

    always_comb
    begin
        vals[2] = a_pix_reg;
        vals[1] = a_r1_reg ? q_eff[PIXEL_W-1:0] : a_pix_reg;
        vals[0] = a_r2_reg ? q_eff[2*PIXEL_W-1:PIXEL_W] : vals[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (a_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // Replicate the left border at the start of a row
                win_reg[i][0] <= a_first_reg ? vals[i] : win_reg[i][1];
                win_reg[i][1] <= a_first_reg ? vals[i] : win_reg[i][2];
                win_reg[i][2] <= vals[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sequencer: issue the pending results lowest bit first.
    // ------------------------------------------------------------------
    logic [1:0] e_sel;
    logic [3:0] e_rest;
    window_t    f_win;
    pixel_t     f_result;
    filt_cfg_t  f_cfg;

    logic          out_valid_reg;
    pixel_t        out_pix_reg;
    logic          out_run_last_reg;
    logic          out_frame_last_reg;

    always_comb
    begin
        priority if (e_mask_reg[0])
        begin
            e_sel = RES_MID;
        end
        else if (e_mask_reg[1])
        begin
            e_sel = RES_MID_EDGE;
        end
        else if (e_mask_reg[2])
        begin
            e_sel = RES_LOW;
        end
        else
        begin
            e_sel = RES_LOW_EDGE;
        end
        e_rest = e_mask_reg & ~(4'b0001 << e_sel);
    end

    assign emit_ok   = !out_valid_reg || out_px.ready;
    assign emit_fire = emit_ok && (e_mask_reg != '0);
    assign e_done    = (e_mask_reg == '0) || (emit_ok && (e_rest == '0));

    // Pick window rows and replicate the right column for the row-end results.
    always_comb
    begin
        logic [1:0] row_src;
        logic [1:0] col_src;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                row_src = (e_sel[1] && i < 2) ? 2'(i + 1) : 2'(i);
                col_src = (e_sel[0] && j == 2) ? 2'd1 : 2'(j);
                f_win[i*3 + j] = win_reg[row_src][col_src];
            end
        end
    end

    assign f_cfg = '{kernel: kernel_reg, edge_only: mode_reg, negate: negate_reg};

    cvse_filter u_filter (
        .win    (f_win),
        .cfg    (f_cfg),
        .result (f_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_mask_reg <= '0;
        end
        else if (a_adv)
        begin
            e_mask_reg <= a_mask_reg;
        end
        else if (emit_fire)
        begin
            e_mask_reg <= e_rest;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_px.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_pix_reg        <= f_result;
            out_run_last_reg   <= (e_rest == '0);
            out_frame_last_reg <= (e_sel == RES_LOW_EDGE);
        end
    end

    assign out_px.valid      = out_valid_reg;
    assign out_px.out_blue   = out_pix_reg[SAMPLE_W-1:0];
    assign out_px.out_green  = out_pix_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign out_px.out_red    = out_pix_reg[3*SAMPLE_W-1:2*SAMPLE_W];
    assign out_px.run_last   = out_run_last_reg;
    assign out_px.frame_last = out_frame_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CVSE_ASSERT_IMP(a_frame_last_ends_run, out_valid_reg && out_frame_last_reg,
                     out_run_last_reg, "frame_last word is not the last of its run")
    `CVSE_ASSERT_IMP(a_run_continues, out_valid_reg && !out_run_last_reg,
                     e_mask_reg != '0, "word shown mid-run but no result left pending")
    `CVSE_ASSERT_NXT(a_frame_wrap, accept && last_col && last_row,
                     col_reg == '0 && row_reg == '0, "counters did not wrap at frame end")

endmodule

// ===== verif/tb_conv3x3_sharpen_edge.sv =====
`timescale 1ns / 1ps

module tb_conv3x3_sharpen_edge;
    import cvse_pkg::*;

    // Run limits and pacing
    localparam int          LATENCY_TAIL    = 8;       // cycles to let in-flight pixels settle
    localparam int          ITEMS_PER_PHASE = 120;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int unsigned SEND_GAP [3]    = '{11, 48, 0};
    localparam int unsigned RECV_STALL [3]  = '{48, 11, 0};

    // The unused kernel code; the block treats it as the Laplacian
    localparam logic [1:0] KERNEL_SPARE = 2'd3;

    // Tap weights, row-major, indexed by kernel code
    localparam int TAPS [3][9] = '{
        '{ 0,  1,  0,  1, -4,  1,  0,  1,  0},
        '{ 1,  2,  1,  0,  0,  0, -1, -2, -1},
        '{ 1,  0, -1,  2,  0, -2,  1,  0, -1}
    };

    // One result word as it leaves the block
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       run_last;
        logic       frame_last;
    } result_t;

    localparam result_t NO_WORD = '0;

    typedef enum logic [1:0] {
        STEP_WRITE,         // register write, block drained first
        STEP_PIXEL,         // pixel word, results from the predictor
        STEP_PIXEL_TYPED    // pixel word, single result typed in the table
    } step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        pixel_t                 pixel;      // red [23:16], green [15:8], blue [7:0]
        result_t                typed_word;
    } dir_step_t;

    localparam int DIR_STEPS = 55;

    // Directed stimulus. A 1x1 frame replicates the pixel into the whole window, so every
    // kernel sums to zero: sharpen mode gives the pixel back and edge mode gives zero.
    dir_step_t directed_steps [DIR_STEPS] = '{
        // 1x1 frames at the reset kernel, mode and negation
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd1, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd1, 24'h0, NO_WORD},
        '{STEP_PIXEL_TYPED, REG_IMAGE_WIDTH, 13'd0, 24'h8000FF,
          '{8'hFF, 8'h00, 8'h80, 1'b1, 1'b1}},
        '{STEP_PIXEL_TYPED, REG_IMAGE_WIDTH, 13'd0, 24'h00FF00,
          '{8'h00, 8'hFF, 8'h00, 1'b1, 1'b1}},
        // edge mode, spare kernel code, negated: flat window gives zero
        '{STEP_WRITE, REG_OUTPUT_MODE, 13'd1, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_KERNEL_SELECT, {11'd0, KERNEL_SPARE}, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_NEGATE_SUM, 13'd1, 24'h0, NO_WORD},
        '{STEP_PIXEL_TYPED, REG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF,
          '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
        // zero width and height fall back to one
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_OUTPUT_MODE, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_NEGATE_SUM, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_KERNEL_SELECT, {11'd0, KERNEL_LAPLACE}, 24'h0, NO_WORD},
        '{STEP_PIXEL_TYPED, REG_IMAGE_WIDTH, 13'd0, 24'h563412,
          '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1}},
        // 3x3 Laplacian edge frame around a bright centre
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd3, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd3, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_OUTPUT_MODE, 13'd1, 24'h0, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h000000, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h102030, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h000000, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h102030, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h4080FF, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h102030, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h000000, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h102030, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, NO_WORD},
        // 2x2 negated horizontal Sobel, sharpen
        '{STEP_WRITE, REG_KERNEL_SELECT, {11'd0, KERNEL_SOBEL_H}, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_NEGATE_SUM, 13'd1, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_OUTPUT_MODE, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd2, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd2, 24'h0, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFF0000, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h00FF00, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h0000FF, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h7F7F7F, NO_WORD},
        // single-row vertical Sobel, edge mode
        '{STEP_WRITE, REG_KERNEL_SELECT, {11'd0, KERNEL_SOBEL_V}, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_NEGATE_SUM, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_OUTPUT_MODE, 13'd1, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd3, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd1, 24'h0, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h000000, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h204060, NO_WORD},
        // 3x4 frame cut short: shrink both sizes while the column counter sits at 2,
        // so the next pixel saturates onto the last column of the last row (four words)
        '{STEP_WRITE, REG_KERNEL_SELECT, {11'd0, KERNEL_LAPLACE}, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_OUTPUT_MODE, 13'd0, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd3, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd4, 24'h0, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFF00FF, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h00FF00, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h808080, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h010203, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFEFDFC, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd2, 24'h0, NO_WORD},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd2, 24'h0, NO_WORD},
        '{STEP_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h55AA55, NO_WORD}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cvse_in_if  pix_in ();
    cvse_out_if pix_out ();

    conv3x3_sharpen_edge uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_px     (pix_in),
        .out_px    (pix_out)
    );

    // Predictor copy of the registers, at reset values
    logic [WIDTH_REG_W-1:0]  frame_width  = 12'd640;
    logic [HEIGHT_REG_W-1:0] frame_height = 13'd480;
    logic [1:0]              kernel_code  = KERNEL_LAPLACE;
    logic                    sum_only     = 1'b0;
    logic                    negate       = 1'b0;

    // Predictor copy of the line stores, window and raster position
    pixel_t      row_two_above [MAX_WIDTH];
    pixel_t      row_above [MAX_WIDTH];
    pixel_t      win_px [9];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    result_t     pixel_words [$];   // words caused by the latest pixel
    result_t     pending_words [$]; // words still owed by the block, oldest first

    int unsigned send_gap_pct   = SEND_GAP[0];
    int unsigned recv_stall_pct = RECV_STALL[0];
    int unsigned pixels_sent    = 0;
    int unsigned words_checked  = 0;
    int unsigned frames_done    = 0;
    int unsigned fail_count     = 0;

    // One channel of one output pixel: weighted sum, optional negation, optional
    // centre add for sharpening, then clamp to a byte.
    function automatic logic [7:0] filter_channel(pixel_t g [9], int ch);
        int         acc;
        logic [1:0] ksel;
        acc  = 0;
        ksel = (kernel_code == KERNEL_SPARE) ? KERNEL_LAPLACE : kernel_code;
        for (int t = 0; t < 9; t++)
            acc += TAPS[ksel][t] * int'(g[t][ch*8 +: 8]);
        if (negate)
            acc = -acc;
        if (!sum_only)
            acc += int'(g[4][ch*8 +: 8]);
        if (acc < 0)
            acc = 0;
        if (acc > 255)
            acc = 255;
        return 8'(acc);
    endfunction

    // Build the 3x3 neighbourhood from window rows ra, rb, rc; repl_right repeats the
    // centre column on the right for the last column of a row.
    function automatic result_t window_word(int ra, int rb, int rc, bit repl_right,
                                            bit flast);
        pixel_t  g [9];
        int      rows [3];
        result_t w;
        rows = '{ra, rb, rc};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                g[i*3+j] = win_px[rows[i]*3 + ((repl_right && j == 2) ? 1 : j)];
        w.blue       = filter_channel(g, 0);
        w.green      = filter_channel(g, 1);
        w.red        = filter_channel(g, 2);
        w.run_last   = 1'b0;
        w.frame_last = flast;
        return w;
    endfunction

    // Advance the predictor by one accepted pixel and leave its words in pixel_words.
    function automatic void filter_pixel(pixel_t p);
        int unsigned w, h, c, r;
        pixel_t      vals [3];
        bit          last_col, last_row;
        w = frame_width;
        h = frame_height;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h == 0)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        // a size shrunk under the counters closes the current row or frame
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;

        // top rows replicate downwards from the first row
        vals[2] = p;
        vals[1] = (r >= 1) ? row_above[c] : p;
        vals[0] = (r >= 2) ? row_two_above[c] : vals[1];
        row_two_above[c] = row_above[c];
        row_above[c]     = p;

        // shift the window left; the first column fills both left columns
        for (int i = 0; i < 3; i++)
        begin
            if (c == 0)
            begin
                win_px[i*3]   = vals[i];
                win_px[i*3+1] = vals[i];
            end
            else
            begin
                win_px[i*3]   = win_px[i*3+1];
                win_px[i*3+1] = win_px[i*3+2];
            end
            win_px[i*3+2] = vals[i];
        end

        last_col = (c == w - 1);
        last_row = (r == h - 1);
        pixel_words.delete();
        if (r >= 1)
        begin
            if (c >= 1)
                pixel_words.push_back(window_word(0, 1, 2, 1'b0, 1'b0));
            if (last_col)
                pixel_words.push_back(window_word(0, 1, 2, 1'b1, 1'b0));
        end
        // the bottom row is flushed along with the last input row
        if (last_row)
        begin
            if (c >= 1)
                pixel_words.push_back(window_word(1, 2, 2, 1'b0, 1'b0));
            if (last_col)
                pixel_words.push_back(window_word(1, 2, 2, 1'b1, 1'b1));
        end
        if (pixel_words.size() > 0)
            pixel_words[pixel_words.size()-1].run_last = 1'b1;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // Drop valid, wait until every owed word has arrived, then hold for tail cycles.
    task automatic drain(input int tail);
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Write one register; only called with the block drained.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   frame_width  = value[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT:  frame_height = value[HEIGHT_REG_W-1:0];
            REG_KERNEL_SELECT: kernel_code  = value[1:0];
            REG_OUTPUT_MODE:   sum_only     = value[0];
            REG_NEGATE_SUM:    negate       = value[0];
            default: ;
        endcase
        // keep the write strobe low between back-to-back writes
        @(posedge clk);
    endtask

    // Offer one pixel word, possibly after random gaps, and book its results once
    // accepted. Valid stays high afterwards so that words can follow back to back.
    task automatic send_pixel(input pixel_t p, input bit typed, input result_t typed_word);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.in_blue  <= p[7:0];
        pix_in.in_green <= p[15:8];
        pix_in.in_red   <= p[23:16];
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        filter_pixel(p);
        if (typed)
            pending_words.push_back(typed_word);
        else
            foreach (pixel_words[i])
                pending_words.push_back(pixel_words[i]);
        pixels_sent++;
    endtask

    // One whole frame with random filter settings. Content is either full-range noise
    // or a smooth patch whose samples lie up to 31 above a random base. With may_shrink the
    // sizes may be cut at a random point mid-frame; they never grow there, so no line
    // store entry is read before it has been written.
    task automatic run_frame(input int unsigned w, input int unsigned h, input bit may_shrink);
        int unsigned shrink_at;
        int unsigned sent;
        bit          smooth;
        logic [7:0]  base_b, base_g, base_r;
        pixel_t      p;
        drain(LATENCY_TAIL);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_KERNEL_SELECT, CFG_DATA_W'($urandom_range(3)));
        write_reg(REG_OUTPUT_MODE, CFG_DATA_W'($urandom_range(1)));
        write_reg(REG_NEGATE_SUM, CFG_DATA_W'($urandom_range(1)));
        smooth    = 1'($urandom_range(1));
        base_b    = 8'($urandom_range(223));
        base_g    = 8'($urandom_range(223));
        base_r    = 8'($urandom_range(223));
        shrink_at = 0;
        if (may_shrink && w * h > 1 && $urandom_range(3) == 0)
            shrink_at = $urandom_range(w * h - 1, 1);
        sent = 0;
        do
        begin
            if (shrink_at != 0 && sent == shrink_at)
            begin
                drain(LATENCY_TAIL);
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(w)));
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(h)));
                write_reg(REG_KERNEL_SELECT, CFG_DATA_W'($urandom_range(3)));
            end
            else if ($urandom_range(39) == 0)
                drain(0);   // hold the sender until the block has caught up
            if (smooth)
                p = {base_r + 8'($urandom_range(31)), base_g + 8'($urandom_range(31)),
                     base_b + 8'($urandom_range(31))};
            else
                p = 24'($urandom());
            send_pixel(p, 1'b0, NO_WORD);
            sent++;
        end
        while (col_pos != 0 || row_pos != 0);
        frames_done++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check each accepted word against the oldest owed word, then
    // decide whether to stall the next cycle.
    initial
    begin
        result_t want;
        pix_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_out.valid && pix_out.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("result word with nothing expected: %0h %0h %0h %0b %0b",
                           pix_out.out_blue, pix_out.out_green, pix_out.out_red,
                           pix_out.run_last, pix_out.frame_last);
                    fail_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (pix_out.out_blue !== want.blue)
                    begin
                        $error("out_blue: expected %0h, got %0h", want.blue, pix_out.out_blue);
                        fail_count++;
                    end
                    if (pix_out.out_green !== want.green)
                    begin
                        $error("out_green: expected %0h, got %0h", want.green,
                               pix_out.out_green);
                        fail_count++;
                    end
                    if (pix_out.out_red !== want.red)
                    begin
                        $error("out_red: expected %0h, got %0h", want.red, pix_out.out_red);
                        fail_count++;
                    end
                    if (pix_out.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b", want.run_last,
                               pix_out.run_last);
                        fail_count++;
                    end
                    if (pix_out.frame_last !== want.frame_last)
                    begin
                        $error("frame_last: expected %0b, got %0b", want.frame_last,
                               pix_out.frame_last);
                        fail_count++;
                    end
                end
                words_checked++;
            end
            pix_out.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: far above the slowest correct run, including both oversize frames
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_conv3x3_sharpen_edge: FAIL");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.in_blue  = '0;
        pix_in.in_green = '0;
        pix_in.in_red   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: writes drain the block first, pixels go through the handshake
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WRITE)
            begin
                drain(LATENCY_TAIL);
                write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_data);
            end
            else
                send_pixel(directed_steps[i].pixel, directed_steps[i].kind == STEP_PIXEL_TYPED,
                           directed_steps[i].typed_word);
        end

        // Random frames: sender-light then receiver-light idling, then none at all
        for (int phase = 0; phase < 3; phase++)
        begin
            int unsigned phase_start;
            send_gap_pct   = SEND_GAP[phase];
            recv_stall_pct = RECV_STALL[phase];
            phase_start    = pixels_sent;
            while (pixels_sent - phase_start < ITEMS_PER_PHASE)
                run_frame(($urandom_range(7) == 0) ? $urandom_range(40, 1)
                                                   : $urandom_range(12, 1),
                          $urandom_range(6, 1), 1'b1);
        end

        // Oversize registers saturate: one full 2048-wide row, one 4096-row column
        run_frame(4095, 1, 1'b0);
        run_frame(1, 8191, 1'b0);

        drain(LATENCY_TAIL);

        $display("Covered %0d pixel words in %0d random frames plus the directed table,",
                 pixels_sent, frames_done);
        $display("%0d result words checked across all kernels, modes, negation and sizes.",
                 words_checked);
        if (fail_count == 0)
            $display("tb_conv3x3_sharpen_edge: PASS");
        else
            $display("tb_conv3x3_sharpen_edge: FAIL");
        $finish;
    end

endmodule
